FILE: hdl/scsu_pkg.sv
`timescale 1ns / 1ps

package scsu_pkg;

  // Series length and output precision
  localparam int SERIES_TERMS = 9;
  localparam int RESULT_FRAC  = 30;
  localparam int WORK_FRAC    = 30;

  // Field and datapath widths
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;
  localparam int X_W     = 33;          // reduced angle, |x| <= pi at 30 fractional bits
  localparam int RED_W   = X_W + 2;     // headroom for the reduction add
  localparam int X2_W    = 34;          // x squared, non-negative
  localparam int TERM_W  = 36;
  localparam int PROD_W  = 38;
  localparam int SUM_W   = 38;
  localparam int RECIP_W = 30;

  // Pipeline timing constant, used by the testbench when it drains
  localparam int LATENCY = 2 * SERIES_TERMS + 2;

  localparam logic signed [RED_W-1:0]   PI_Q30     = RED_W'(64'd3373259426);
  localparam logic signed [RED_W-1:0]   TWO_PI_Q30 = RED_W'(64'd6746518852);
  localparam logic signed [TERM_W-1:0]  TERM_ONE   = TERM_W'(64'd1 << WORK_FRAC);
  localparam logic signed [SUM_W-1:0]   SUM_ONE    = SUM_W'(64'd1 << WORK_FRAC);
  localparam logic signed [VALUE_W-1:0] VALUE_ONE  = VALUE_W'(64'd1 << RESULT_FRAC);

  typedef enum logic {
    OP_SINE   = 1'b0,
    OP_COSINE = 1'b1
  } scsu_op_e;

  // One item as it travels down the term chain
  typedef struct packed {
    logic                      valid;
    scsu_op_e                  op;
    logic [X2_W-1:0]           x2;
    logic signed [TERM_W-1:0]  term;
    logic signed [SUM_W-1:0]   sum;
  } scsu_lane_t;

endpackage

FILE: hdl/scsu_term.sv
`timescale 1ns / 1ps

module scsu_term (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scsu_pkg::scsu_lane_t          lane_i,
  input  logic [scsu_pkg::RECIP_W-1:0]  recip_sin_i,
  input  logic [scsu_pkg::RECIP_W-1:0]  recip_cos_i,
  output scsu_pkg::scsu_lane_t          lane_o
);
  import scsu_pkg::*;

  logic                          a_valid_q;
  scsu_op_e                      a_op_q;
  logic [X2_W-1:0]               a_x2_q;
  logic signed [SUM_W-1:0]       a_sum_d, a_sum_q;
  logic signed [PROD_W-1:0]      a_prod_d, a_prod_q;
  logic signed [TERM_W+X2_W:0]   prod_full;
  logic [RECIP_W-1:0]            recip;
  logic signed [PROD_W+RECIP_W:0] scale_full;
  logic signed [TERM_W-1:0]      term_d;
  logic                          b_valid_q;
  scsu_op_e                      b_op_q;
  logic [X2_W-1:0]               b_x2_q;
  logic signed [SUM_W-1:0]       b_sum_q;
  logic signed [TERM_W-1:0]      b_term_q;

  // Stage A: previous term times x squared, fold previous term into the sum
  always_comb begin
    prod_full = $signed(lane_i.term) * $signed({1'b0, lane_i.x2});
    a_prod_d  = prod_full[WORK_FRAC +: PROD_W];
    a_sum_d   = $signed(lane_i.sum) + SUM_W'($signed(lane_i.term));
  end

  // Stage B: scale by the reciprocal step constant and negate
  always_comb begin
    recip      = (a_op_q == OP_COSINE) ? recip_cos_i : recip_sin_i;
    scale_full = a_prod_q * $signed({1'b0, recip});
    term_d     = -$signed(scale_full[WORK_FRAC +: TERM_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= lane_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_op_q   <= lane_i.op;
    a_x2_q   <= lane_i.x2;
    a_sum_q  <= a_sum_d;
    a_prod_q <= a_prod_d;
    b_op_q   <= a_op_q;
    b_x2_q   <= a_x2_q;
    b_sum_q  <= a_sum_q;
    b_term_q <= term_d;
  end

  assign lane_o = '{valid: b_valid_q, op: b_op_q, x2: b_x2_q, term: b_term_q, sum: b_sum_q};

  a_valid_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_o.valid == $past(lane_i.valid, 2))
    else $error("term stage lost or invented an item");

endmodule

FILE: hdl/sine_cosine_series_unit.sv
`timescale 1ns / 1ps

// Sine / cosine by a fixed-point Taylor series. Assert start_i with opcode_i
// (0 sine, 1 cosine) and a Q3.28 angle in radians on angle_i; busy_o is always
// low, so a new angle may be transferred on every clock. The angle is reduced
// once into [-pi, pi], squared, and the seed term and nine further series terms
// are summed, each further term costing two multiplier stages. Each result
// appears on value_o as a Q1.30 value saturated to [-1, 1], with valid_o high
// for exactly one cycle, after passing the reduction, squaring, term chain and
// output registers; results leave in input order. The receiver cannot hold results
// off and must take each one in the cycle it is shown.

module sine_cosine_series_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 opcode_i,
  input  logic signed [scsu_pkg::ANGLE_W-1:0]  angle_i,
  output logic                                 valid_o,
  output logic signed [scsu_pkg::VALUE_W-1:0]  value_o
);
  import scsu_pkg::*;

  // Reduction stage
  logic                         accept;
  logic signed [RED_W-1:0]      x_ext, x_sub, x_add;
  logic signed [X_W-1:0]        x_d, x_q;
  logic                         s1_valid_q;
  scsu_op_e                     s1_op_q;

  // Squaring stage
  logic signed [2*X_W-1:0]      sq_full;
  scsu_lane_t                   lane [SERIES_TERMS+1];
  scsu_lane_t                   s2_d;
  logic                         lane0_valid_q;
  scsu_op_e                     lane0_op_q;
  logic [X2_W-1:0]              lane0_x2_q;
  logic signed [TERM_W-1:0]     lane0_term_q;
  logic signed [SUM_W-1:0]      lane0_sum_q;

  // Output stage
  logic signed [SUM_W-1:0]      sum_f, sat;
  logic signed [VALUE_W-1:0]    value_d, value_q;
  logic                         valid_q;

  // The pipeline never stalls: every start is a transfer
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Widen to 30 fractional bits, then at most one add or subtract of 2*pi
  always_comb begin
    x_ext = RED_W'($signed({angle_i, 2'b00}));
    x_sub = x_ext - TWO_PI_Q30;
    x_add = x_ext + TWO_PI_Q30;
    if (x_ext > PI_Q30) begin
      x_d = X_W'(x_sub);
    end else if (x_ext < -PI_Q30) begin
      x_d = X_W'(x_add);
    end else begin
      x_d = X_W'(x_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    s1_op_q <= scsu_op_e'(opcode_i);
  end

  // Square and seed the series: cosine starts from one, sine from x
  always_comb begin
    sq_full    = x_q * x_q;
    s2_d.valid = s1_valid_q;
    s2_d.op    = s1_op_q;
    s2_d.x2    = sq_full[WORK_FRAC +: X2_W];
    s2_d.term  = (s1_op_q == OP_COSINE) ? TERM_ONE : TERM_W'(x_q);
    s2_d.sum   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane0_valid_q <= 1'b0;
    end else begin
      lane0_valid_q <= s2_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    lane0_op_q   <= s2_d.op;
    lane0_x2_q   <= s2_d.x2;
    lane0_term_q <= s2_d.term;
    lane0_sum_q  <= s2_d.sum;
  end

  assign lane[0] = '{valid: lane0_valid_q, op: lane0_op_q, x2: lane0_x2_q,
                     term: lane0_term_q, sum: lane0_sum_q};

  // Term chain: each stage multiplies by x^2 and by the rounded reciprocal
  // of the next factorial step, (2k)(2k+1) for sine and (2k-1)(2k) for cosine
  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
    localparam longint ONE_W    = longint'(1) << WORK_FRAC;
    localparam longint DIV_SIN  = longint'(2 * k) * longint'(2 * k + 1);
    localparam longint DIV_COS  = longint'(2 * k - 1) * longint'(2 * k);
    localparam longint RCP_SIN  = (ONE_W + DIV_SIN / 2) / DIV_SIN;
    localparam longint RCP_COS  = (ONE_W + DIV_COS / 2) / DIV_COS;

    scsu_term u_term (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .lane_i      (lane[k-1]),
      .recip_sin_i (RECIP_W'(RCP_SIN)),
      .recip_cos_i (RECIP_W'(RCP_COS)),
      .lane_o      (lane[k])
    );
  end

  // Add the last term, saturate to [-1, 1], floor to the result precision
  always_comb begin
    sum_f = $signed(lane[SERIES_TERMS].sum) + SUM_W'($signed(lane[SERIES_TERMS].term));
    if (sum_f > SUM_ONE) begin
      sat = SUM_ONE;
    end else if (sum_f < -SUM_ONE) begin
      sat = -SUM_ONE;
    end else begin
      sat = sum_f;
    end
    value_d = VALUE_W'(sat >>> (WORK_FRAC - RESULT_FRAC));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= lane[SERIES_TERMS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

  a_reduced_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (RED_W'(x_q) <= PI_Q30) && (RED_W'(x_q) >= -PI_Q30))
    else $error("angle reduction left x outside [-pi, pi]");

  a_value_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (value_o <= VALUE_ONE) && (value_o >= -VALUE_ONE))
    else $error("result outside [-1, 1]");

  a_chain_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(lane[SERIES_TERMS].valid))
    else $error("output strobe out of step with term chain");

endmodule

FILE: test/tb_sine_cosine_series_unit.sv
`timescale 1ns / 1ps

module tb_sine_cosine_series_unit;
  import scsu_pkg::*;

  // Run shape
  localparam int RANDOM_ITEMS   = 830;
  localparam int QUIET_FIRST    = 380;   // random items in this window never idle
  localparam int QUIET_LAST     = 560;
  localparam int IDLE_PERCENT   = 23;
  localparam int WATCHDOG_LIMIT = 2000;

  // Predictor constants, 30 fractional bits
  localparam longint PI_FIX     = 64'sd3373259426;
  localparam longint TWO_PI_FIX = 64'sd6746518852;
  localparam longint ONE_FIX    = 64'sd1 <<< WORK_FRAC;

  // Angles that sit on the edges of the reduction window (angle * 4 vs pi)
  localparam logic [31:0] PI_IN     = 32'd843314856;   // x just below pi
  localparam logic [31:0] PI_ABOVE  = 32'd843314857;   // x just above pi
  localparam logic [31:0] HALF_PI   = 32'd421657428;
  localparam logic [31:0] ONE_RAD   = 32'd268435456;

  typedef struct packed {
    scsu_op_e    op;
    logic [31:0] angle;
    logic        typed;      // result is written in the row
    logic [31:0] value;
  } stim_row_t;

  typedef struct {
    scsu_op_e                   op;
    logic signed [ANGLE_W-1:0]  angle;
    logic signed [VALUE_W-1:0]  value;
  } pending_value_t;

  // Zero angles have exact answers; everything else goes through the predictor.
  localparam int DIRECTED_COUNT = 21;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{OP_SINE,   32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_COSINE, 32'h0000_0000, 1'b1, 32'h4000_0000},
    '{OP_SINE,   32'h0000_0001, 1'b0, 32'h0},
    '{OP_COSINE, 32'h0000_0001, 1'b0, 32'h0},
    '{OP_SINE,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_COSINE, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_SINE,   32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_COSINE, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_SINE,   32'h8000_0000, 1'b0, 32'h0},
    '{OP_COSINE, 32'h8000_0000, 1'b0, 32'h0},
    '{OP_SINE,   PI_IN,         1'b0, 32'h0},
    '{OP_SINE,   PI_ABOVE,      1'b0, 32'h0},
    '{OP_SINE,   -PI_IN,        1'b0, 32'h0},
    '{OP_SINE,   -PI_ABOVE,     1'b0, 32'h0},
    '{OP_COSINE, PI_IN,         1'b0, 32'h0},
    '{OP_COSINE, PI_ABOVE,      1'b0, 32'h0},
    '{OP_COSINE, -PI_IN,        1'b0, 32'h0},
    '{OP_COSINE, -PI_ABOVE,     1'b0, 32'h0},
    '{OP_SINE,   HALF_PI,       1'b0, 32'h0},
    '{OP_SINE,   -HALF_PI,      1'b0, 32'h0},
    '{OP_SINE,   ONE_RAD,       1'b0, 32'h0}
  };

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       opcode_i = 1'b0;
  logic signed [ANGLE_W-1:0]  angle_i = '0;
  logic                       busy_o;
  logic                       valid_o;
  logic signed [VALUE_W-1:0]  value_o;

  // Side-band that travels with the item on start_i: a value typed into the table
  logic                       typed_q = 1'b0;
  logic signed [VALUE_W-1:0]  typed_value_q = '0;

  pending_value_t pending_values[$];
  pending_value_t oldest;
  int             mismatches = 0;
  int             idle_cycles = 0;
  int             sine_checked = 0;
  int             cosine_checked = 0;
  int             saturated_seen = 0;
  int             reduced_seen = 0;
  longint         quad_angle;

  sine_cosine_series_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .opcode_i (opcode_i),
    .angle_i  (angle_i),
    .valid_o  (valid_o),
    .value_o  (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor(a * b / 2^30), exact through a 128-bit product
  function automatic longint floor_mul_q30(longint a, longint b);
    logic signed [127:0] prod;
    prod = a * b;
    return longint'(prod >>> WORK_FRAC);
  endfunction

  // Expected series value for one angle: reduce, square, sum the terms,
  // saturate, then drop to the output precision.
  function automatic logic signed [VALUE_W-1:0] series_value(scsu_op_e op,
                                                            logic signed [ANGLE_W-1:0] ang);
    longint      x;
    logic [63:0] mag;
    longint      x2;
    longint      term;
    longint      sum;
    longint      d;
    longint      recip;
    x = longint'(ang) * 4;
    if (x > PI_FIX) begin
      x = x - TWO_PI_FIX;
    end else if (x < -PI_FIX) begin
      x = x + TWO_PI_FIX;
    end
    mag  = (x < 0) ? 64'(-x) : 64'(x);
    x2   = longint'((mag * mag) >> WORK_FRAC);
    term = (op == OP_COSINE) ? ONE_FIX : x;
    sum  = term;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      if (op == OP_COSINE) begin
        d = longint'(2 * k - 1) * longint'(2 * k);
      end else begin
        d = longint'(2 * k) * longint'(2 * k + 1);
      end
      recip = (ONE_FIX + d / 2) / d;
      term  = -floor_mul_q30(floor_mul_q30(term, x2), recip);
      sum   = sum + term;
    end
    if (sum > ONE_FIX) begin
      sum = ONE_FIX;
    end
    if (sum < -ONE_FIX) begin
      sum = -ONE_FIX;
    end
    return VALUE_W'(sum >>> (WORK_FRAC - RESULT_FRAC));
  endfunction

  // Record every input transfer and check every result strobe. Both are
  // sampled at the edge, before any driver update of the same step lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Retire first, so a result never meets its own expectation in one step
      if (valid_o) begin
        if (pending_values.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %0d", $time, value_o);
        end else begin
          oldest = pending_values.pop_front();
          if (value_o !== oldest.value) begin
            mismatches++;
            $display("%0t: op %0d angle %0d: expected %0d, got %0d", $time,
                     oldest.op, oldest.angle, oldest.value, value_o);
          end
          if (oldest.op == OP_COSINE) begin
            cosine_checked++;
          end else begin
            sine_checked++;
          end
          if (oldest.value == VALUE_ONE || oldest.value == -VALUE_ONE) begin
            saturated_seen++;
          end
        end
      end
      if (start_i && !busy_o) begin
        quad_angle = longint'(angle_i) * 4;
        if (quad_angle > PI_FIX || quad_angle < -PI_FIX) begin
          reduced_seen++;
        end
        pending_values.push_back('{op: scsu_op_e'(opcode_i), angle: angle_i,
                                   value: typed_q ? typed_value_q
                                                  : series_value(scsu_op_e'(opcode_i), angle_i)});
      end
      // Restart the watchdog on any transfer in either direction
      if (valid_o || (start_i && !busy_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Hold the item on the ports until an edge transfers it.
  task automatic drive_item(scsu_op_e op, logic signed [ANGLE_W-1:0] ang,
                            logic typed, logic signed [VALUE_W-1:0] value);
    start_i       <= 1'b1;
    opcode_i      <= op;
    angle_i       <= ang;
    typed_q       <= typed;
    typed_value_q <= value;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start now and then, one cycle at a time, so that about
  // IDLE_PERCENT of the cycles carry no item.
  task automatic maybe_idle(bit allowed);
    if (allowed) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  initial begin
    logic signed [ANGLE_W-1:0] ang;
    int                        offset;
    // Hold reset, then release it on an edge
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: extremes, both opcodes, both sides of the reduction window
    for (int row = 0; row < DIRECTED_COUNT; row++) begin
      drive_item(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].angle,
                 DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].value);
      maybe_idle(1'b1);
    end

    // Random angles, weighted toward the reduction edges, the saturation
    // points around +-pi/2 and tiny arguments
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      offset = int'($urandom_range(0, 4000)) - 2000;
      case ($urandom_range(0, 9))
        0, 1, 2: ang = $urandom;
        3, 4:    ang = PI_IN + offset;
        5:       ang = HALF_PI + offset;
        6:       ang = $signed($urandom_range(0, 65535));
        7:       ang = {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
        default: ang = $signed($urandom_range(0, 32'h3200_0000));
      endcase
      // Mirror half of them to negative angles
      if ($urandom_range(0, 1)) begin
        ang = -ang;
      end
      drive_item(scsu_op_e'($urandom_range(0, 1)), ang, 1'b0, '0);
      maybe_idle(!(n >= QUIET_FIRST && n < QUIET_LAST));
    end
    start_i <= 1'b0;

    // Drain, then give any stray strobe time to show up
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("Checked %0d sine and %0d cosine results.", sine_checked, cosine_checked);
    $display("Angles reduced by 2*pi: %0d, results at +-1.0: %0d, mismatches: %0d.",
             reduced_seen, saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("** sine_cosine_series_unit: PASSED **");
    end else begin
      $display("** sine_cosine_series_unit: FAILED **");
    end
    $finish;
  end

  // End the run if nothing transfers for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** sine_cosine_series_unit: FAILED **");
    $finish;
  end

endmodule
